[rtl/core/gfalu_pkg.sv]
`timescale 1ns / 1ps
package gfalu_pkg;

	localparam int FIELD_M = 131;
	localparam int DEG_W   = 8;

	typedef logic [FIELD_M-1:0] elem_t;
	typedef logic [FIELD_M:0]   poly_t;
	typedef logic [DEG_W-1:0]   deg_t;

	// x^13 + x^2 + x + 1, the part of the field polynomial below x^131
	localparam elem_t RED_TAIL = elem_t'(16'h2007);
	localparam poly_t P_FULL   = {1'b1, RED_TAIL};
	localparam deg_t  DEG_TOP  = deg_t'(FIELD_M);
	localparam deg_t  MUL_LAST = deg_t'(FIELD_M - 1);

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_MUL = 2'd1,
		ACT_SQR = 2'd2,
		ACT_INV = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_INV,
		S_WB
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_step;
		logic inv_step;
		logic wb;
	} ctl_cmd_t;

	typedef struct packed {
		logic du_zero;
	} dp_stat_t;

endpackage

[rtl/core/gf2_131_field_alu.sv]
// GF(2^131) arithmetic unit, field polynomial x^131 + x^13 + x^2 + x + 1.
// Input channel: in_valid/in_ready with action and operands a, b (each split
// into lo, mid, hi). Output channel: out_valid/out_ready with r_lo/r_mid/r_hi.
// action: add (xor), multiply, square of a, inverse of a (inverse of 0 is 1).
// One item is worked at a time; in_ready is high only while the unit is idle,
// so the next item is taken the cycle after the previous one is written back.
// Work per action:
//   add         a^b is formed when the item is accepted
//   mul, square 131 bit-serial shift-and-reduce steps, MSB of b first
//   inverse     one Euclid step per cycle, either a one-bit normalize
//               shift of u or an aligned u^v with a barrel shift of the
//               cofactor; the shifts walk deg(u)+deg(v) down from 262
//               and every u^v is followed by at least one shift.
// The result sits in an output register; when the receiver stalls, the unit
// holds the finished item in its write-back state and accepts nothing new
// until the output register frees up.
// Reset (arst_n low) returns the controller to idle and drops out_valid.
`timescale 1ns / 1ps
module gf2_131_field_alu
	import gfalu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [63:0] a_lo,
	input  logic [63:0] a_mid,
	input  logic [2:0]  a_hi,
	input  logic [63:0] b_lo,
	input  logic [63:0] b_mid,
	input  logic [2:0]  b_hi,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] r_lo,
	output logic [63:0] r_mid,
	output logic [2:0]  r_hi
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	gfalu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	gfalu_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.action (action),
		.a_lo   (a_lo),
		.a_mid  (a_mid),
		.a_hi   (a_hi),
		.b_lo   (b_lo),
		.b_mid  (b_mid),
		.b_hi   (b_hi),
		.r_lo   (r_lo),
		.r_mid  (r_mid),
		.r_hi   (r_hi)
	);

endmodule

[rtl/core/gfalu_dp.sv]
`timescale 1ns / 1ps
module gfalu_dp
	import gfalu_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  ctl_cmd_t        cmd,
	output dp_stat_t        stat,
	input  logic [1:0]      action,
	input  logic [63:0]     a_lo,
	input  logic [63:0]     a_mid,
	input  logic [2:0]      a_hi,
	input  logic [63:0]     b_lo,
	input  logic [63:0]     b_mid,
	input  logic [2:0]      b_hi,
	output logic [63:0]     r_lo,
	output logic [63:0]     r_mid,
	output logic [2:0]      r_hi
);

	elem_t   a_in;
	elem_t   b_in;
	action_t act;

	elem_t   a_q;
	elem_t   b_q;
	elem_t   acc_q;
	poly_t   u_q;
	poly_t   v_q;
	deg_t    du_q;
	deg_t    dv_q;
	elem_t   g_q;
	elem_t   h_q;
	logic    is_inv_q;
	elem_t   r_q;

	elem_t   mul_next;
	logic    swap;
	deg_t    shamt;
	elem_t   sh_src;
	elem_t   sh_val;
	poly_t   uv_xor;

	assign a_in = {a_hi, a_mid, a_lo};
	assign b_in = {b_hi, b_mid, b_lo};
	assign act  = action_t'(action);

	always_comb begin
		mul_next = {acc_q[FIELD_M-2:0], 1'b0};
		if (acc_q[FIELD_M-1]) begin
			mul_next = mul_next ^ RED_TAIL;
		end
		if (b_q[FIELD_M-1]) begin
			mul_next = mul_next ^ a_q;
		end
	end

	always_comb begin
		swap   = du_q < dv_q;
		shamt  = swap ? dv_q - du_q : du_q - dv_q;
		sh_src = swap ? g_q : h_q;
		sh_val = sh_src << shamt;
		uv_xor = u_q ^ v_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q      <= a_in;
			b_q      <= (act == ACT_SQR) ? a_in : b_in;
			acc_q    <= (act == ACT_ADD) ? (a_in ^ b_in) : '0;
			u_q      <= {1'b0, a_in};
			v_q      <= P_FULL;
			du_q     <= DEG_TOP;
			dv_q     <= DEG_TOP;
			g_q      <= elem_t'(1);
			h_q      <= '0;
			is_inv_q <= (act == ACT_INV);
		end else if (cmd.mul_step) begin
			acc_q <= mul_next;
			b_q   <= b_q << 1;
		end else if (cmd.inv_step) begin
			if (!u_q[FIELD_M]) begin
				// normalize: bring the leading coefficient of u to the top
				u_q  <= {u_q[FIELD_M-1:0], 1'b0};
				du_q <= du_q - 1'b1;
			end else begin
				u_q <= uv_xor;
				g_q <= (swap ? h_q : g_q) ^ sh_val;
				if (swap) begin
					v_q  <= u_q;
					dv_q <= du_q;
					du_q <= dv_q;
					h_q  <= g_q;
				end
			end
		end
		if (cmd.wb) begin
			r_q <= is_inv_q ? g_q : acc_q;
		end
	end

	assign stat.du_zero = (du_q == '0);

	assign r_lo  = r_q[63:0];
	assign r_mid = r_q[127:64];
	assign r_hi  = r_q[FIELD_M-1:128];

	a_v_lead: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.inv_step |-> (v_q[FIELD_M] && dv_q != '0))
		else $error("v lost its leading coefficient");

	a_xor_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.inv_step && u_q[FIELD_M]) |=> !u_q[FIELD_M])
		else $error("reduction step left u leading bit set");

	a_norm_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.inv_step && !u_q[FIELD_M]) |=> du_q == deg_t'($past(du_q) - 1'b1))
		else $error("normalize step did not lower degree of u");

endmodule

[rtl/core/gfalu_ctrl.sv]
`timescale 1ns / 1ps
module gfalu_ctrl
	import gfalu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	output logic       out_valid,
	input  logic       out_ready,
	output ctl_cmd_t   cmd,
	input  dp_stat_t   stat
);

	state_t  state_q;
	state_t  state_d;
	deg_t    cnt_q;
	logic    out_valid_q;
	logic    out_free;
	action_t act;

	assign act      = action_t'(action);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (act)
						ACT_ADD: state_d = S_WB;
						ACT_MUL: state_d = S_MUL;
						ACT_SQR: state_d = S_MUL;
						ACT_INV: state_d = S_INV;
						default: state_d = S_WB;
					endcase
				end
			end
			S_MUL: begin
				if (cnt_q == MUL_LAST) begin
					state_d = S_WB;
				end
			end
			S_INV: begin
				if (stat.du_zero) begin
					state_d = S_WB;
				end
			end
			S_WB: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == S_IDLE);
		cmd.load     = (state_q == S_IDLE) && in_valid;
		cmd.mul_step = (state_q == S_MUL);
		cmd.inv_step = (state_q == S_INV) && !stat.du_zero;
		cmd.wb       = (state_q == S_WB) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.mul_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.wb) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_mul_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL && cnt_q == MUL_LAST) |=> state_q == S_WB)
		else $error("multiply did not finish after the last step");

	a_load_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cnt_q == '0)
		else $error("step counter not cleared on load");

	a_wb_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb |=> (out_valid_q && state_q == S_IDLE))
		else $error("write back did not present a result");

endmodule

[bench/gf2_131_field_alu_tb.sv]
`timescale 1ns / 1ps
module gf2_131_field_alu_tb;
	import gfalu_pkg::*;

	localparam int WIDE_W      = 320;
	localparam int INV_CAP     = 1024;
	localparam int RAND_ITEMS  = 1950;
	localparam int QUIET_LIMIT = 8000;
	localparam int HOLD_CYCLES = 1000;
	localparam int HOLD_AFTER  = 300;
	localparam int DRAIN_WAIT  = 300;

	localparam elem_t ELEM_ZERO = '0;
	localparam elem_t ELEM_ONE  = elem_t'(1);
	localparam elem_t ELEM_X    = elem_t'(2);
	localparam elem_t ELEM_ALL  = '1;
	localparam elem_t ELEM_TOP  = elem_t'(1) << (FIELD_M - 1);
	localparam elem_t ELEM_HI3  = elem_t'(7) << (FIELD_M - 3);

	typedef logic [WIDE_W-1:0] wide_t;

	typedef struct {
		action_t act;
		elem_t   a;
		elem_t   b;
	} op_item_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [1:0]  action    = '0;
	logic [63:0] a_lo      = '0;
	logic [63:0] a_mid     = '0;
	logic [2:0]  a_hi      = '0;
	logic [63:0] b_lo      = '0;
	logic [63:0] b_mid     = '0;
	logic [2:0]  b_hi      = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] r_lo;
	logic [63:0] r_mid;
	logic [2:0]  r_hi;

	op_item_t pending_ops[$];
	elem_t    expected_results[$];
	op_item_t next_op;

	int error_count    = 0;
	int accepted_items = 0;
	int checked_items  = 0;
	int act_count[4]   = '{0, 0, 0, 0};
	int burst_left     = 0;
	int gap_left       = 0;
	int hold_left      = 0;
	bit hold_done      = 1'b0;
	int ready_mode     = 0;
	int cycle_count    = 0;
	int quiet_cycles   = 0;

	gf2_131_field_alu uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.a_lo     (a_lo),
		.a_mid    (a_mid),
		.a_hi     (a_hi),
		.b_lo     (b_lo),
		.b_mid    (b_mid),
		.b_hi     (b_hi),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.r_lo     (r_lo),
		.r_mid    (r_mid),
		.r_hi     (r_hi)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int poly_degree(wide_t p);
		for (int i = WIDE_W - 1; i > 0; i--)
			if (p[i])
				return i;
		return 0;
	endfunction

	function automatic elem_t gf_reduce(wide_t t);
		for (int i = WIDE_W - 1; i >= FIELD_M; i--)
			if (t[i]) begin
				t[i] = 1'b0;
				t = t ^ (wide_t'(RED_TAIL) << (i - FIELD_M));
			end
		return t[FIELD_M-1:0];
	endfunction

	function automatic elem_t gf_mul(elem_t x, elem_t y);
		wide_t acc;
		acc = '0;
		for (int i = 0; i < FIELD_M; i++)
			if (y[i])
				acc = acc ^ (wide_t'(x) << i);
		return gf_reduce(acc);
	endfunction

	function automatic elem_t gf_inverse(elem_t x);
		wide_t u, v, g, h, t;
		int    du, dv, shift, steps;
		u = wide_t'(x);
		v = wide_t'(P_FULL);
		g = wide_t'(1);
		h = '0;
		steps = 0;
		du = poly_degree(u);
		while (du != 0 && steps < INV_CAP) begin
			dv = poly_degree(v);
			if (du < dv) begin
				t = u; u = v; v = t;
				t = g; g = h; h = t;
				shift = dv - du;
			end else begin
				shift = du - dv;
			end
			u = u ^ (v << shift);
			g = g ^ (h << shift);
			steps++;
			du = poly_degree(u);
		end
		return gf_reduce(g);
	endfunction

	function automatic elem_t field_result(action_t act, elem_t x, elem_t y);
		case (act)
			ACT_ADD: return x ^ y;
			ACT_MUL: return gf_mul(x, y);
			ACT_SQR: return gf_mul(x, x);
			default: return gf_inverse(x);
		endcase
	endfunction

	function automatic elem_t rand_elem();
		logic [159:0] raw;
		raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		case ($urandom_range(0, 9))
			0: return elem_t'(1) << $urandom_range(0, FIELD_M - 1);
			1: return ELEM_ALL;
			2: return elem_t'(raw[7:0]);
			3: return $urandom_range(0, 1) ? ELEM_ONE : ELEM_ZERO;
			4: return raw[FIELD_M-1:0] | ELEM_TOP;
			default: return raw[FIELD_M-1:0];
		endcase
	endfunction

	task automatic queue_op(action_t act, elem_t x, elem_t y);
		op_item_t op;
		op.act = act;
		op.a = x;
		op.b = y;
		pending_ops = {pending_ops, op};
	endtask

	// driver: bursts of items separated by random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results = {expected_results, field_result(action_t'(action),
					{a_hi, a_mid, a_lo}, {b_hi, b_mid, b_lo})};
				act_count[action]++;
				accepted_items++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0 || pending_ops.size() == 0) begin
					in_valid <= 1'b0;
					if (gap_left != 0)
						gap_left--;
				end else begin
					next_op = pending_ops.pop_front();
					in_valid <= 1'b1;
					action   <= next_op.act;
					a_lo     <= next_op.a[63:0];
					a_mid    <= next_op.a[127:64];
					a_hi     <= next_op.a[130:128];
					b_lo     <= next_op.b[63:0];
					b_mid    <= next_op.b[127:64];
					b_hi     <= next_op.b[130:128];
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 16);
						case ($urandom_range(0, 3))
							0: gap_left = 0;
							1: gap_left = $urandom_range(30, 200);
							default: gap_left = $urandom_range(1, 8);
						endcase
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// monitor: receiver stall pattern, one long hold-off, result check
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			cycle_count++;
			if (cycle_count % 1024 == 0)
				ready_mode = $urandom_range(0, 3);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no item pending: r = %h", {r_hi, r_mid, r_lo});
					error_count++;
				end else begin
					elem_t want;
					want = expected_results.pop_front();
					checked_items++;
					if (r_lo !== want[63:0]) begin
						$error("r_lo: expected %h, got %h", want[63:0], r_lo);
						error_count++;
					end
					if (r_mid !== want[127:64]) begin
						$error("r_mid: expected %h, got %h", want[127:64], r_mid);
						error_count++;
					end
					if (r_hi !== want[130:128]) begin
						$error("r_hi: expected %h, got %h", want[130:128], r_hi);
						error_count++;
					end
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && accepted_items >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				case (ready_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 7) == 0);
					default: out_ready <= (cycle_count[4:2] != 3'd0);
				endcase
			end
		end
	end

	// watchdog: cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("gf2_131_field_alu_tb: FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		queue_op(ACT_ADD, ELEM_ZERO, ELEM_ZERO);
		queue_op(ACT_ADD, ELEM_ALL, ELEM_ALL);
		queue_op(ACT_ADD, ELEM_ALL, ELEM_ZERO);
		queue_op(ACT_ADD, ELEM_TOP, ELEM_ONE);
		queue_op(ACT_MUL, ELEM_ZERO, ELEM_ALL);
		queue_op(ACT_MUL, ELEM_ONE, rand_elem());
		queue_op(ACT_MUL, rand_elem(), ELEM_ONE);
		queue_op(ACT_MUL, ELEM_ALL, ELEM_ALL);
		queue_op(ACT_MUL, ELEM_TOP, ELEM_TOP);
		queue_op(ACT_MUL, ELEM_TOP, ELEM_X);
		queue_op(ACT_MUL, ELEM_HI3, ELEM_ALL);
		queue_op(ACT_SQR, ELEM_ZERO, ELEM_ALL);
		queue_op(ACT_SQR, ELEM_ONE, ELEM_ZERO);
		queue_op(ACT_SQR, ELEM_ALL, rand_elem());
		queue_op(ACT_SQR, ELEM_TOP, ELEM_ALL);
		queue_op(ACT_INV, ELEM_ZERO, ELEM_ALL);
		queue_op(ACT_INV, ELEM_ONE, ELEM_ZERO);
		queue_op(ACT_INV, ELEM_X, ELEM_ZERO);
		queue_op(ACT_INV, ELEM_ALL, ELEM_ALL);
		queue_op(ACT_INV, ELEM_TOP, ELEM_ZERO);
		queue_op(ACT_INV, ELEM_HI3, rand_elem());
		queue_op(ACT_INV, rand_elem(), rand_elem());
		for (int i = 0; i < RAND_ITEMS; i++)
			queue_op(action_t'($urandom_range(0, 3)), rand_elem(), rand_elem());

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("gf2_131_field_alu_tb: %0d items (add %0d, mul %0d, square %0d, inverse %0d)",
			accepted_items, act_count[0], act_count[1], act_count[2], act_count[3]);
		$display("gf2_131_field_alu_tb: %0d results checked, %0d mismatches",
			checked_items, error_count);
		if (error_count == 0 && expected_results.size() == 0)
			$display("gf2_131_field_alu_tb: PASS");
		else
			$display("gf2_131_field_alu_tb: FAIL");
		$finish;
	end

endmodule

[gf2_131_field_alu.f]
rtl/core/gfalu_pkg.sv
rtl/core/gfalu_dp.sv
rtl/core/gfalu_ctrl.sv
rtl/core/gf2_131_field_alu.sv
bench/gf2_131_field_alu_tb.sv
